// ===== sv/lcp_pkg.sv =====
package lcp_pkg;

	// fixed field widths
	localparam int SENSOR_W   = 8;
	localparam int SPEED_W    = 8;
	localparam int GAIN_W     = 24;
	localparam int POS_W      = 13;
	localparam int CNT_W      = 4;
	localparam int ERR_W      = 15;
	localparam int DERIV_W    = 16;
	localparam int POS_SUM_W  = 16;
	localparam int CMP_W      = 16;
	localparam int SPD_W      = 14;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 88;

	// sensor array and scaling
	localparam int SENSOR_COUNT = 8;
	localparam int POS_STEP     = 1000;
	localparam int FRAC_BITS    = 16;
	localparam int SPEED_SCALE  = 13;
	localparam int CMP_LIMIT    = 65535 / SPEED_SCALE;
	localparam logic [CMP_W-1:0] CMP_MAX = 16'hFFFF;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RIGHT  = 3'd5;

	localparam logic [GAIN_W-1:0]  RST_GAIN_PROP  = 24'd983;
	localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG = 24'd197;
	localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV = 24'd655360;
	localparam logic [POS_W-1:0]   RST_TARGET_POS = 13'd3750;
	localparam logic [SPEED_W-1:0] RST_MAX_LEFT   = 8'd100;
	localparam logic [SPEED_W-1:0] RST_MAX_RIGHT  = 8'd100;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_prop;
		logic [GAIN_W-1:0]  gain_integ;
		logic [GAIN_W-1:0]  gain_deriv;
		logic [POS_W-1:0]   target_position;
		logic [SPEED_W-1:0] max_left;
		logic [SPEED_W-1:0] max_right;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic [POS_SUM_W-1:0] pos_sum;
		logic [CNT_W-1:0]     count;
		logic [SPEED_W-1:0]   base_left;
		logic [SPEED_W-1:0]   base_right;
	} item_t;

	typedef struct packed {
		logic [CMP_W-1:0] right_reverse;
		logic [CMP_W-1:0] right_forward;
		logic [CMP_W-1:0] left_reverse;
		logic [CMP_W-1:0] left_forward;
		logic             drive_valid;
		logic [CNT_W-1:0] sensors_on;
		logic [POS_W-1:0] line_position;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_ERR,
		B_MUL,
		B_CORR,
		B_SPD,
		B_CMP
	} back_state_t;

endpackage

// ===== sv/line_centroid_pid_motor_drive.sv =====
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | s_tdata: sensor_bits, base_left, base_right
// m       | out       | m_tvalid/m_tready  | m_tdata: position, count, drive flag, compares
// cfg     | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// in the back end one sample passes through a fifo pop, the two-bit-per-cycle centroid
// divider, error update, the shared 18x25 multiplier, then truncation, speed clamp and
// compare. arst_n clears gains to their defaults, the error window and the previous
// error to zero. the front takes new samples into a two-entry queue while the back end
// works, and the back end works on the next sample while a result waits in the output
// register, holding in the compare step until that result is taken.
module line_centroid_pid_motor_drive #(
	parameter int SUM_WINDOW = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] sensor_bits, [15:8] base_left, [23:16] base_right
	input  logic [lcp_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [12:0] line_position, [16:13] sensors_on, [17] drive_valid, [33:18] left_forward,
	// [49:34] left_reverse, [65:50] right_forward, [81:66] right_reverse, rest zero
	output logic [lcp_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [lcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lcp_pkg::*;

	localparam int PAD_W = OUT_DATA_W - $bits(result_t);

	cfg_t    cfg_q;
	item_t   front_item;
	item_t   fifo_item;
	logic    push;
	logic    full;
	logic    fifo_pop;
	logic    fifo_empty;
	result_t result;

	// config registers, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop       <= RST_GAIN_PROP;
			cfg_q.gain_integ      <= RST_GAIN_INTEG;
			cfg_q.gain_deriv      <= RST_GAIN_DERIV;
			cfg_q.target_position <= RST_TARGET_POS;
			cfg_q.max_left        <= RST_MAX_LEFT;
			cfg_q.max_right       <= RST_MAX_RIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_PROP:  cfg_q.gain_prop       <= cfg_data[GAIN_W-1:0];
				REG_GAIN_INTEG: cfg_q.gain_integ      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DERIV: cfg_q.gain_deriv      <= cfg_data[GAIN_W-1:0];
				REG_TARGET_POS: cfg_q.target_position <= cfg_data[POS_W-1:0];
				REG_MAX_LEFT:   cfg_q.max_left        <= cfg_data[SPEED_W-1:0];
				REG_MAX_RIGHT:  cfg_q.max_right       <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// front: input register and sensor popcount / weighted sum
	lcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (full),
		.push     (push),
		.item     (front_item)
	);

	// decoupling queue between front and back
	lcp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (full),
		.pop    (fifo_pop),
		.dout   (fifo_item),
		.empty  (fifo_empty)
	);

	// back: centroid divide, pid terms, speed split
	lcp_back #(
		.SUM_WINDOW (SUM_WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (fifo_empty),
		.fifo_item  (fifo_item),
		.fifo_pop   (fifo_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.result     (result)
	);

	assign m_tdata = {{PAD_W{1'b0}}, result};

endmodule

// ===== sv/lcp_front.sv =====
module lcp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lcp_pkg::IN_DATA_W-1:0]    s_tdata,  // sensor_bits, base_left, base_right
	input  logic                             full,
	output logic                             push,
	output lcp_pkg::item_t                   item
);
	import lcp_pkg::*;

	localparam int NBITS  = (SENSOR_COUNT < SENSOR_W) ? SENSOR_COUNT : SENSOR_W;
	localparam int WSUM_W = $clog2(NBITS * (NBITS + 1) / 2 + 1);

	logic                  valid_s1;
	logic [IN_DATA_W-1:0]  data_s1;
	logic [CNT_W-1:0]      cnt_c;
	logic [WSUM_W-1:0]     wsum_c;

	assign s_tready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	// popcount and weighted sum of set sensors
	always_comb begin
		cnt_c  = '0;
		wsum_c = '0;
		for (int k = 0; k < NBITS; k++) begin
			if (data_s1[k]) begin
				cnt_c  = cnt_c + CNT_W'(1);
				wsum_c = wsum_c + WSUM_W'(k + 1);
			end
		end
	end

	always_comb begin
		item.pos_sum    = POS_SUM_W'(wsum_c * POS_STEP);
		item.count      = cnt_c;
		item.base_left  = data_s1[SENSOR_W +: SPEED_W];
		item.base_right = data_s1[SENSOR_W + SPEED_W +: SPEED_W];
	end

endmodule

// ===== sv/lcp_fifo.sv =====
module lcp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcp_pkg::item_t din,
	output logic           full,
	input  logic           pop,
	output lcp_pkg::item_t dout,
	output logic           empty
);
	import lcp_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   fill_q;

	assign full  = (fill_q == (PTR_W + 1)'(DEPTH));
	assign empty = (fill_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

// ===== sv/lcp_div.sv =====
module lcp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lcp_pkg::POS_SUM_W-1:0]   dividend,
	input  logic [lcp_pkg::CNT_W-1:0]       divisor,
	output logic                            done,
	output logic [lcp_pkg::POS_SUM_W-1:0]   quotient
);
	import lcp_pkg::*;

	// two restoring steps per cycle
	localparam int STEPS = POS_SUM_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [POS_SUM_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_c;
	logic [POS_SUM_W-1:0] quo_c;
	logic [CNT_W:0]    t_c;

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_comb begin
		rem_c = rem_q;
		quo_c = quo_q;
		t_c   = '0;
		for (int j = 0; j < 2; j++) begin
			t_c   = {rem_c, quo_c[POS_SUM_W-1]};
			quo_c = {quo_c[POS_SUM_W-2:0], 1'b0};
			if (t_c >= {1'b0, div_q}) begin
				t_c      = t_c - {1'b0, div_q};
				quo_c[0] = 1'b1;
			end
			rem_c = t_c[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_c;
			quo_q <= quo_c;
		end
	end

endmodule

// ===== sv/lcp_back.sv =====
module lcp_back #(
	parameter int SUM_WINDOW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcp_pkg::cfg_t    cfg,
	input  logic             fifo_empty,
	input  lcp_pkg::item_t   fifo_item,
	output logic             fifo_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output lcp_pkg::result_t result
);
	import lcp_pkg::*;

	localparam int INTEG_W = ERR_W + $clog2(SUM_WINDOW + 1);
	localparam int MUL_A_W = INTEG_W;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int CORR_W  = ACC_W - FRAC_BITS;
	localparam int SUM_W   = CORR_W + 1;
	localparam int HIST_D  = (SUM_WINDOW > 1) ? SUM_WINDOW - 1 : 1;
	localparam logic [1:0] MUL_LAST = 2'd3;
	localparam logic signed [SUM_W-1:0] SPD_LO = SUM_W'(-(CMP_LIMIT + 1));

	back_state_t state_q, state_d;
	logic        div_start;
	logic        div_done;
	logic [POS_SUM_W-1:0] div_quo;
	logic        out_load;

	item_t                      item_q;
	logic [POS_W-1:0]           pos_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [ERR_W-1:0]    prev_err_q;
	logic signed [DERIV_W-1:0]  deriv_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [INTEG_W-1:0]  hist_sum;
	logic [1:0]                 mcnt_q;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_adj;
	logic signed [CORR_W-1:0]   corr_q;
	logic signed [SUM_W-1:0]    left_full;
	logic signed [SUM_W-1:0]    right_full;
	logic signed [SUM_W-1:0]    max_l_ext;
	logic signed [SUM_W-1:0]    max_r_ext;
	logic signed [SPD_W-1:0]    left_q;
	logic signed [SPD_W-1:0]    right_q;
	logic [POS_W-1:0]           pos_c;
	logic signed [ERR_W-1:0]    err_c;
	logic signed [INTEG_W-1:0]  err_ext;
	logic                       out_valid_q;
	result_t                    out_q;

	function automatic logic [CMP_W-1:0] cmp_value(input logic signed [SPD_W-1:0] spd,
			input logic rev);
		logic [SPD_W-1:0] mag;
		logic [CMP_W-1:0] res;
		mag = rev ? SPD_W'(-spd) : spd;
		if (rev ? (spd >= 0) : (spd < 0)) begin
			res = '0;
		end else if (mag > SPD_W'(CMP_LIMIT)) begin
			res = CMP_MAX;
		end else begin
			res = CMP_W'(mag) * CMP_W'(SPEED_SCALE);
		end
		return res;
	endfunction

	lcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (fifo_item.pos_sum),
		.divisor  (fifo_item.count),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (!fifo_empty) state_d = B_DIV;
			B_DIV:  if (div_done) state_d = B_ERR;
			B_ERR:  state_d = B_MUL;
			B_MUL:  if (mcnt_q == MUL_LAST) state_d = B_CORR;
			B_CORR: state_d = B_SPD;
			B_SPD:  state_d = B_CMP;
			B_CMP:  if (!out_valid_q || m_tready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		fifo_pop  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			B_IDLE: begin
				fifo_pop  = !fifo_empty;
				div_start = !fifo_empty;
			end
			B_CMP: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// error terms
	assign pos_c   = (item_q.count == '0) ? '0 : div_quo[POS_W-1:0];
	assign err_c   = $signed({2'b00, cfg.target_position}) - $signed({2'b00, pos_c});
	assign err_ext = {{(INTEG_W - ERR_W){err_c[ERR_W-1]}}, err_c};

	generate
		if (SUM_WINDOW > 1) begin : g_hist
			logic signed [ERR_W-1:0]   hist_q [HIST_D];
			logic signed [INTEG_W-1:0] hist_sum_q;
			logic signed [INTEG_W-1:0] oldest_ext;

			assign oldest_ext = {{(INTEG_W - ERR_W){hist_q[HIST_D-1][ERR_W-1]}},
				hist_q[HIST_D-1]};
			assign hist_sum   = hist_sum_q;

			// running sum of the window, oldest error drops out
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int k = 0; k < HIST_D; k++) begin
						hist_q[k] <= '0;
					end
					hist_sum_q <= '0;
				end else if (state_q == B_ERR) begin
					for (int k = HIST_D - 1; k > 0; k--) begin
						hist_q[k] <= hist_q[k-1];
					end
					hist_q[0]  <= err_c;
					hist_sum_q <= hist_sum_q + err_ext - oldest_ext;
				end
			end
		end else begin : g_nohist
			assign hist_sum = '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (state_q == B_ERR) begin
			prev_err_q <= err_c;
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (mcnt_q)
			2'd0: begin
				mul_a = {{(MUL_A_W - ERR_W){err_q[ERR_W-1]}}, err_q};
				mul_b = $signed({1'b0, cfg.gain_prop});
			end
			2'd1: begin
				mul_a = integ_q;
				mul_b = $signed({1'b0, cfg.gain_integ});
			end
			default: begin
				mul_a = {{(MUL_A_W - DERIV_W){deriv_q[DERIV_W-1]}}, deriv_q};
				mul_b = $signed({1'b0, cfg.gain_deriv});
			end
		endcase
	end

	// truncate toward zero
	assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'((2 ** FRAC_BITS) - 1) : ACC_W'(0));

	assign max_l_ext  = $signed({{(SUM_W - SPEED_W){1'b0}}, cfg.max_left});
	assign max_r_ext  = $signed({{(SUM_W - SPEED_W){1'b0}}, cfg.max_right});
	assign left_full  = $signed({{(SUM_W - SPEED_W){1'b0}}, item_q.base_left})
		+ {corr_q[CORR_W-1], corr_q};
	assign right_full = $signed({{(SUM_W - SPEED_W){1'b0}}, item_q.base_right})
		- {corr_q[CORR_W-1], corr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (state_q == B_ERR) begin
			mcnt_q <= '0;
		end else if (state_q == B_MUL) begin
			mcnt_q <= mcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			item_q <= fifo_item;
		end
		case (state_q)
			B_ERR: begin
				pos_q   <= pos_c;
				err_q   <= err_c;
				deriv_q <= {err_c[ERR_W-1], err_c} - {prev_err_q[ERR_W-1], prev_err_q};
				integ_q <= err_ext + hist_sum;
				acc_q   <= '0;
			end
			B_MUL: begin
				prod_q <= mul_a * mul_b;
				if (mcnt_q != 2'd0) begin
					acc_q <= acc_q + {{2{prod_q[PROD_W-1]}}, prod_q};
				end
			end
			B_CORR: corr_q <= acc_adj[ACC_W-1:FRAC_BITS];
			B_SPD: begin
				// clamp above by config; clamp below only where compare saturates anyway
				if (left_full > max_l_ext) begin
					left_q <= max_l_ext[SPD_W-1:0];
				end else if (left_full < SPD_LO) begin
					left_q <= SPD_LO[SPD_W-1:0];
				end else begin
					left_q <= left_full[SPD_W-1:0];
				end
				if (right_full > max_r_ext) begin
					right_q <= max_r_ext[SPD_W-1:0];
				end else if (right_full < SPD_LO) begin
					right_q <= SPD_LO[SPD_W-1:0];
				end else begin
					right_q <= right_full[SPD_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.line_position <= pos_q;
			out_q.sensors_on    <= item_q.count;
			out_q.drive_valid   <= (item_q.count != '0);
			out_q.left_forward  <= cmp_value(left_q, 1'b0);
			out_q.left_reverse  <= cmp_value(left_q, 1'b1);
			out_q.right_forward <= cmp_value(right_q, 1'b0);
			out_q.right_reverse <= cmp_value(right_q, 1'b1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign result   = out_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == B_IDLE) && !fifo_empty)
		else $error("divider started outside idle");
	a_load_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == B_CMP)
		else $error("result appeared without compare step");
	a_drive_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.drive_valid == (out_q.sensors_on != '0)))
		else $error("drive flag disagrees with sensor count");
	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.left_forward == '0 || out_q.left_reverse == '0)
			&& (out_q.right_forward == '0 || out_q.right_reverse == '0))
		else $error("forward and reverse both driven");

endmodule
